// File: src/mrq_pkg.sv
// Shared types and codes for the multilevel ready queue.
package mrq_pkg;
  localparam logic [1:0] OP_TAIL = 2'd0;
  localparam logic [1:0] OP_HEAD = 2'd1;
  localparam logic [1:0] OP_REM  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOTFD = 2'd2;

  localparam logic [1:0] MODE_FIFO  = 2'd0;
  localparam logic [1:0] MODE_RR    = 2'd1;
  localparam logic [1:0] MODE_MULTI = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_LEVS = 2'd1;
  localparam logic [1:0] REG_MASK = 2'd2;

  typedef struct packed {
    logic [1:0] sched_mode;
    logic [3:0] levels_in_use;
    logic [7:0] rr_level_mask;
  } cfg_t;
endpackage

// File: src/multilevel_ready_queue_top.sv
// Ready queue of process ids kept in up to LEVELS levels of SLOTS entries each. The ids
// live in one single-port-read entry memory, the per-level counts in registers, and one
// input beat is handled at a time. After the accept edge a dispatch state handles a tail
// insert, a head insert in multilevel mode walks the level shifting it down, and a remove
// walks the level searching and closing the gap. Then a state starts the head read, a scan
// over the levels in use (only level 0 outside multilevel mode) sums the counts and picks
// the head, and a state loads the result register. The next input beat is taken once the
// queue is back idle after that load; a result beat still held by the receiver stalls only
// the load of the following result.
module multilevel_ready_queue_top
  import mrq_pkg::*;
#(
  parameter int LEVELS = 8,
  parameter int SLOTS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], proc_id[33:2], priority_req[41:34], zero pad to 48
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], level_used[4:2], head_valid[5], head_id[37:6],
  // head_level[40:38], total_count[48:41], quantum_flag[49], pad to 56
  output logic [55:0] m_axis_tdata
);
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int AW = LW + SW;
  localparam int TW = $clog2(LEVELS * SLOTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_HRD  = 3'd3;
  localparam logic [2:0] S_HCK  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  cfg_t cfg;
  mrq_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  logic [2:0] state_q, state_d;
  logic [1:0] op_q;
  logic [31:0] id_q, carry_q, carry_d;
  logic [LW-1:0] lvl_q, lvl_d, hl_q, hl_d, scan_q, scan_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q [LEVELS];
  logic found_q, found_d, multi_q, quant_q, hv_q, hv_d;
  logic [1:0] st_q, st_d;
  logic [31:0] hid_q, hid_d;
  logic [TW-1:0] tot_q, tot_d;
  logic [3:0] nlev_q;
  logic [55:0] out_q;
  logic ov_q;

  logic we, cnt_inc, cnt_dec, in_acc, out_load, head_mode, quant, last_lvl;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;
  logic [CW-1:0] cnt;

  logic [1:0] in_op;
  logic [31:0] in_id;
  logic [7:0] in_pri;
  logic in_multi;
  logic [3:0] in_nlev;
  logic [LW-1:0] in_lvl;

  mrq_mem #(.DEPTH(LEVELS * (1 << SW)), .AW(AW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign in_op = s_axis_tdata[1:0];
  assign in_id = s_axis_tdata[33:2];
  assign in_pri = s_axis_tdata[41:34];
  assign in_multi = cfg.sched_mode == MODE_MULTI;
  always_comb begin
    in_nlev = cfg.levels_in_use;
    if (in_nlev == 4'd0) in_nlev = 4'd1;
    if (32'(in_nlev) > LEVELS) in_nlev = 4'(LEVELS);
    if (!in_multi) in_nlev = 4'd1;
    if (!in_multi) in_lvl = '0;
    else if ({4'd0, in_pri} >= {8'd0, in_nlev}) in_lvl = LW'(in_nlev - 4'd1);
    else in_lvl = LW'(in_pri);
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_load = state_q == S_OUT && (!ov_q || m_axis_tready);
  assign cnt = cnt_q[lvl_q];
  assign head_mode = op_q == OP_HEAD && multi_q;
  assign last_lvl = {1'b0, 4'(scan_q)} + 5'd1 >= {1'b0, nlev_q};

  always_comb begin
    state_d = state_q; lvl_d = lvl_q; idx_d = idx_q; carry_d = carry_q;
    found_d = found_q; st_d = st_q; hl_d = hl_q; hv_d = hv_q; hid_d = hid_q;
    tot_d = tot_q; scan_d = scan_q;
    we = 1'b0; waddr = '0; wdata = carry_q; raddr = '0;
    cnt_inc = 1'b0; cnt_dec = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          lvl_d = in_lvl; idx_d = '0; found_d = 1'b0; st_d = ST_DONE;
          carry_d = in_id;
          state_d = S_RD;
        end
      end
      S_RD: begin
        // dispatch the operation; walks start reading index idx
        raddr = {lvl_q, SW'(idx_q)};
        state_d = S_HRD;
        if (op_q == OP_TAIL || op_q == OP_HEAD) begin
          if (cnt >= CW'(SLOTS)) st_d = ST_FULL;
          else if (!head_mode) begin
            we = 1'b1; waddr = {lvl_q, SW'(cnt)}; wdata = id_q; cnt_inc = 1'b1;
          end else state_d = S_CMP;
        end else if (op_q == OP_REM) begin
          if (cnt == '0) st_d = ST_NOTFD;
          else state_d = S_CMP;
        end
        if (state_d == S_HRD) begin
          hl_d = '0; tot_d = '0; hv_d = 1'b0; hid_d = '0; scan_d = '0;
        end
      end
      S_CMP: begin
        // rdata holds entry idx; read idx+1 in parallel
        raddr = {lvl_q, SW'(idx_q + CW'(1))};
        idx_d = idx_q + CW'(1);
        if (head_mode) begin
          we = 1'b1; waddr = {lvl_q, SW'(idx_q)}; wdata = carry_q; carry_d = rdata;
          if (idx_q == cnt) begin cnt_inc = 1'b1; state_d = S_HRD; end
        end else begin
          if (found_q) begin
            we = 1'b1; waddr = {lvl_q, SW'(idx_q - CW'(1))}; wdata = rdata;
          end
          if (rdata == id_q) found_d = 1'b1;
          if (idx_q + CW'(1) == cnt) begin
            state_d = S_HRD;
            if (found_d) cnt_dec = 1'b1; else st_d = ST_NOTFD;
          end
        end
        if (state_d == S_HRD) begin
          hl_d = '0; tot_d = '0; hv_d = 1'b0; hid_d = '0; scan_d = '0;
        end
      end
      S_HRD: begin
        raddr = {scan_q, SW'(0)};
        state_d = S_HCK;
      end
      S_HCK: begin
        // rdata holds the head entry of level scan; read the next level's head
        tot_d = tot_q + TW'(cnt_q[scan_q]);
        if (!hv_q && cnt_q[scan_q] != '0) begin
          hv_d = 1'b1; hid_d = rdata; hl_d = scan_q;
        end
        if (last_lvl) state_d = S_OUT;
        else begin
          scan_d = scan_q + LW'(1);
          raddr = {scan_d, SW'(0)};
        end
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cfg.sched_mode == MODE_RR) quant = 1'b1;
    else if (in_multi) quant = (32'(in_lvl) < 8) ? cfg.rr_level_mask[3'(in_lvl)] : 1'b0;
    else quant = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q <= 1'b0;
      for (int k = 0; k < LEVELS; k++) cnt_q[k] <= '0;
      lvl_q <= '0; idx_q <= '0; carry_q <= '0; found_q <= 1'b0; st_q <= ST_DONE;
      hl_q <= '0; hv_q <= 1'b0; hid_q <= '0; tot_q <= '0; scan_q <= '0;
      op_q <= OP_TAIL; id_q <= '0; multi_q <= 1'b0; quant_q <= 1'b0; nlev_q <= 4'd1;
      out_q <= '0;
    end else begin
      state_q <= state_d;
      lvl_q <= lvl_d; idx_q <= idx_d; carry_q <= carry_d; found_q <= found_d;
      st_q <= st_d; hv_q <= hv_d; hid_q <= hid_d; tot_q <= tot_d;
      hl_q <= hl_d; scan_q <= scan_d;
      if (cnt_inc) cnt_q[lvl_q] <= cnt + CW'(1);
      else if (cnt_dec) cnt_q[lvl_q] <= cnt - CW'(1);
      if (in_acc) begin
        op_q <= in_op; id_q <= in_id; multi_q <= in_multi; quant_q <= quant;
        nlev_q <= in_nlev;
      end
      if (out_load) begin
        out_q <= {6'd0, quant_q, 8'(tot_q), hv_q ? 3'(hl_q) : 3'd0, hid_q, hv_q,
                  3'(lvl_q), st_q};
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt <= CW'(SLOTS));
  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q <= S_OUT);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> op_q == OP_REM || head_mode);
endmodule

// File: src/mrq_cfg.sv
// APB configuration registers of the ready queue.
module mrq_cfg
  import mrq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);
  cfg_t cfg_q;
  logic wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx = paddr[3:2];
  assign wr = psel && penable && pwrite;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sched_mode <= MODE_FIFO;
      cfg_q.levels_in_use <= 4'd1;
      cfg_q.rr_level_mask <= 8'd0;
    end else if (wr && paddr[1:0] == 2'd0) begin
      case (idx)
        REG_MODE: cfg_q.sched_mode <= pwdata[1:0];
        REG_LEVS: cfg_q.levels_in_use <= pwdata[3:0];
        REG_MASK: cfg_q.rr_level_mask <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'd0) begin
      case (idx)
        REG_MODE: prdata = {30'd0, cfg_q.sched_mode};
        REG_LEVS: prdata = {28'd0, cfg_q.levels_in_use};
        REG_MASK: prdata = {24'd0, cfg_q.rr_level_mask};
        default: prdata = 32'd0;
      endcase
    end
  end
endmodule

// File: src/mrq_mem.sv
// Entry store: one write port, one registered read port.
module mrq_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: tb/multilevel_ready_queue_top_tb.sv
// Randomized stream test of the multilevel ready queue against a behavioral scoreboard.
`timescale 1ns / 1ps
module multilevel_ready_queue_top_tb
  import mrq_pkg::*;
;

  localparam int LEVELS = 8;
  localparam int SLOTS  = 16;

  typedef struct packed {
    logic        quantum_flag;
    logic [7:0]  total_count;
    logic [2:0]  head_level;
    logic [31:0] head_id;
    logic        head_valid;
    logic [2:0]  level_used;
    logic [1:0]  status;
  } qres_t;

  class ready_queue_scoreboard;
    logic [31:0] slot_id [LEVELS][SLOTS];
    int unsigned lvl_cnt [LEVELS];
    logic [1:0]  mode;
    logic [3:0]  levs;
    logic [7:0]  mask;
    qres_t       pending [$];
    int          errors;

    function new();
      foreach (lvl_cnt[i]) lvl_cnt[i] = 0;
      mode = MODE_FIFO;
      levs = 4'd1;
      mask = 8'd0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == REG_MODE) mode = val[1:0];
      else if (idx == REG_LEVS) levs = val[3:0];
      else if (idx == REG_MASK) mask = val[7:0];
    endfunction

    function void note_item(logic [1:0] op, logic [31:0] id, logic [7:0] pri);
      qres_t r;
      bit multi;
      int unsigned nlev, lvl, cnt, pos, total;
      multi = (mode == MODE_MULTI);
      nlev = 1;
      if (multi) begin
        nlev = (levs == 0) ? 1 : ((levs > LEVELS) ? LEVELS : levs);
      end
      lvl = 0;
      if (multi) lvl = (pri >= nlev) ? nlev - 1 : pri;
      cnt = lvl_cnt[lvl];
      r = '0;
      if (op == OP_TAIL || op == OP_HEAD) begin
        if (cnt >= SLOTS) begin
          r.status = ST_FULL;
        end else if (op == OP_HEAD && multi) begin
          for (int i = cnt; i > 0; i--) slot_id[lvl][i] = slot_id[lvl][i-1];
          slot_id[lvl][0] = id;
          lvl_cnt[lvl] = cnt + 1;
        end else begin
          slot_id[lvl][cnt] = id;
          lvl_cnt[lvl] = cnt + 1;
        end
      end else if (op == OP_REM) begin
        pos = cnt;
        for (int i = 0; i < cnt; i++) begin
          if (slot_id[lvl][i] == id) begin
            pos = i;
            break;
          end
        end
        if (pos == cnt) begin
          r.status = ST_NOTFD;
        end else begin
          for (int i = pos; i + 1 < cnt; i++) slot_id[lvl][i] = slot_id[lvl][i+1];
          lvl_cnt[lvl] = cnt - 1;
        end
      end
      if (mode == MODE_RR) r.quantum_flag = 1'b1;
      else if (multi) r.quantum_flag = mask[lvl];
      total = 0;
      for (int i = 0; i < nlev; i++) begin
        total += lvl_cnt[i];
        if (!r.head_valid && lvl_cnt[i] != 0) begin
          r.head_valid = 1'b1;
          r.head_id = slot_id[i][0];
          r.head_level = 3'(i);
        end
      end
      r.level_used = 3'(lvl);
      r.total_count = 8'(total);
      pending.push_back(r);
    endfunction

    function void check_result(logic [55:0] data);
      qres_t a, e;
      a = qres_t'(data[49:0]);
      if (pending.size() == 0) begin
        $error("unexpected result beat %h", data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.level_used !== e.level_used) begin
        $error("level_used exp %0d got %0d", e.level_used, a.level_used); errors++;
      end
      if (a.head_valid !== e.head_valid) begin
        $error("head_valid exp %0d got %0d", e.head_valid, a.head_valid); errors++;
      end
      if (a.head_id !== e.head_id) begin
        $error("head_id exp %h got %h", e.head_id, a.head_id); errors++;
      end
      if (a.head_level !== e.head_level) begin
        $error("head_level exp %0d got %0d", e.head_level, a.head_level); errors++;
      end
      if (a.total_count !== e.total_count) begin
        $error("total_count exp %0d got %0d", e.total_count, a.total_count); errors++;
      end
      if (a.quantum_flag !== e.quantum_flag) begin
        $error("quantum_flag exp %0d got %0d", e.quantum_flag, a.quantum_flag); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  int  src_idle_pct = 0;
  int  snk_idle_pct = 0;
  bit  hold_go = 1'b0;
  logic sink_hold = 1'b0;
  bit  stim_done = 1'b0;
  logic [31:0] id_pool [8];

  ready_queue_scoreboard sb = new();

  multilevel_ready_queue_top dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (sink_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk_i);
    sink_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic configure(logic [1:0] mode, logic [3:0] levs, logic [7:0] mask);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    write_reg(REG_MODE, {30'd0, mode});
    write_reg(REG_LEVS, {28'd0, levs});
    write_reg(REG_MASK, {24'd0, mask});
  endtask

  task automatic send_item(logic [1:0] op, logic [31:0] id, logic [7:0] pri);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, pri, id, op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, id, pri);
  endtask

  task automatic random_items(int n);
    logic [1:0]  op;
    logic [31:0] id;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 45) op = OP_TAIL;
      else if (r < 60) op = OP_HEAD;
      else if (r < 97) op = OP_REM;
      else op = OP_NONE;
      id = ($urandom_range(3) == 0) ? $urandom() : id_pool[$urandom_range(7)];
      if (op != OP_REM && $urandom_range(3) == 0) id_pool[$urandom_range(7)] = id;
      send_item(op, id, ($urandom_range(4) == 0) ? 8'($urandom()) : 8'($urandom_range(9)));
    end
  endtask

  initial begin
    foreach (id_pool[i]) id_pool[i] = $urandom();
    id_pool[0] = 32'hFFFF_FFFF;
    id_pool[1] = 32'h0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    src_idle_pct = 15;
    snk_idle_pct = 53;
    send_item(OP_TAIL, 32'h0, 8'h00);
    send_item(OP_TAIL, 32'hFFFF_FFFF, 8'hFF);
    send_item(OP_HEAD, 32'hA5A5_5A5A, 8'h01);
    send_item(OP_REM, 32'h1234_5678, 8'h00);
    send_item(OP_NONE, 32'h5, 8'h7);
    send_item(OP_REM, 32'h0, 8'h00);
    for (int i = 0; i < 17; i++) send_item(OP_TAIL, 32'hFFFF_FFFF, 8'h00);
    configure(MODE_MULTI, 4'd8, 8'hAA);
    send_item(OP_HEAD, 32'h0000_0001, 8'h03);
    send_item(OP_TAIL, 32'h0000_0002, 8'hFF);
    send_item(OP_REM, 32'hFFFF_FFFF, 8'h00);
    send_item(OP_NONE, 32'h0, 8'hFF);
    random_items(250);
    configure(MODE_RR, 4'd0, 8'h00);
    random_items(150);
    configure(MODE_MULTI, 4'd15, 8'hFF);
    src_idle_pct = 53;
    snk_idle_pct = 15;
    random_items(250);
    configure(MODE_RSVD, 4'd3, 8'h55);
    random_items(150);
    configure(MODE_MULTI, 4'd1, 8'h01);
    random_items(100);
    configure(MODE_MULTI, 4'd4, 8'h5A);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_go = 1'b1;
    random_items(300);
    configure(MODE_FIFO, 4'd8, 8'h00);
    random_items(100);
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) $display("multilevel_ready_queue_top_tb OK");
    else $display("multilevel_ready_queue_top_tb NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("multilevel_ready_queue_top_tb NOT OK");
    $finish;
  end
endmodule
